// ----- hdl/pbfl_pkg.sv -----
// packet buffer free list: shared constants, codes and structs
// no dependencies; used by the interfaces, controller, datapath and top level
package pbfl_pkg;

  // pool geometry
  localparam int MAX_BUFFERS       = 1024;
  localparam int BUFFERS_PER_PAGE  = 2;
  localparam int PAGE_BYTES        = 4096;
  localparam int MAX_PAGES_PER_ADD = 8;
  localparam int STEP_BYTES        = PAGE_BYTES / BUFFERS_PER_PAGE;
  localparam int POOL_PAGE_LIMIT   = MAX_BUFFERS / BUFFERS_PER_PAGE;

  // field and internal widths
  localparam int ACT_W  = 2;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 32;
  localparam int ST_W   = 2;
  localparam int ID_W   = $clog2(MAX_BUFFERS);
  localparam int LINK_W = $clog2(MAX_BUFFERS + 1);
  localparam int USED_W = LINK_W;
  localparam int PAGE_W = $clog2(POOL_PAGE_LIMIT + 1);
  localparam int SUM_W  = ((PAGE_W > CNT_W) ? PAGE_W : CNT_W) + 1;
  localparam int WALK_W = $clog2(MAX_PAGES_PER_ADD * BUFFERS_PER_PAGE + 1);

  // action codes
  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GET = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PUT = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_ERROR = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // execute a single-step item, or start an add walk
    logic step;   // push one buffer of an add walk
    logic done;   // close an add walk
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk;       // current item is an add that walks buffers
    logic walk_last;  // the walk is on its final buffer
  } sts_t;

  // result item
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   given_id;
    logic [ADDR_W-1:0] given_address;
    logic              put_on_empty;
    logic [USED_W-1:0] used_count;
  } res_t;

endpackage

// ----- hdl/pbfl_if.sv -----
// packet buffer free list: request and response channel interfaces
// depends on pbfl_pkg
interface pbfl_in_if;
  logic                         valid;
  logic                         ready;
  logic [pbfl_pkg::ACT_W-1:0]   action;
  logic [pbfl_pkg::CNT_W-1:0]   page_count;
  logic [pbfl_pkg::ADDR_W-1:0]  base_address;
  logic [pbfl_pkg::ID_W-1:0]    buffer_id;

  modport source (output valid, action, page_count, base_address, buffer_id, input ready);
  modport sink   (input valid, action, page_count, base_address, buffer_id, output ready);
endinterface

interface pbfl_out_if;
  logic                         valid;
  logic                         ready;
  logic [pbfl_pkg::ST_W-1:0]    status;
  logic [pbfl_pkg::ID_W-1:0]    given_id;
  logic [pbfl_pkg::ADDR_W-1:0]  given_address;
  logic                         put_on_empty;
  logic [pbfl_pkg::USED_W-1:0]  used_count;

  modport source (output valid, status, given_id, given_address, put_on_empty, used_count,
                  input ready);
  modport sink   (input valid, status, given_id, given_address, put_on_empty, used_count,
                  output ready);
endinterface

// ----- hdl/pbfl_ctrl.sv -----
// packet buffer free list: controller state machine and output valid flag
// depends on pbfl_pkg
module pbfl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pbfl_pkg::sts_t sts_i,
  output pbfl_pkg::cmd_t cmd_o
);
  import pbfl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       res_load;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    res_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.walk) begin
          cmd_o.exec = 1'b1;
          state_d    = S_WALK;
        end else if (out_free) begin
          cmd_o.exec = 1'b1;
          res_load   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.done = 1'b1;
          res_load   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register valid flag
  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/pbfl_datapath.sv -----
// packet buffer free list: list head, counters, link and address memories, result register
// depends on pbfl_pkg
module pbfl_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbfl_pkg::cmd_t              cmd_i,
  output pbfl_pkg::sts_t              sts_o,
  input  logic [pbfl_pkg::ACT_W-1:0]  action_i,
  input  logic [pbfl_pkg::CNT_W-1:0]  page_count_i,
  input  logic [pbfl_pkg::ADDR_W-1:0] base_address_i,
  input  logic [pbfl_pkg::ID_W-1:0]   buffer_id_i,
  output pbfl_pkg::res_t              res_o
);
  import pbfl_pkg::*;

  // captured item
  logic [ACT_W-1:0]  action_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] base_q;
  logic [ID_W-1:0]   id_q;

  // list state
  logic [ID_W-1:0]   head_id_q, head_id_d;
  logic              head_valid_q, head_valid_d;
  logic [PAGE_W-1:0] pages_q, pages_d;
  logic [USED_W-1:0] used_q, used_d;

  // add walk
  logic [ID_W-1:0]   nid_q;
  logic [WALK_W-1:0] off_q, total_q;
  logic [ADDR_W-1:0] addr_q;

  // memories with registered read at the head
  logic [LINK_W-1:0] link_mem [MAX_BUFFERS];
  logic [ADDR_W-1:0] addr_mem [MAX_BUFFERS];
  logic [LINK_W-1:0] rd_link_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              link_we, addr_we;
  logic [ID_W-1:0]   link_wa;
  logic [LINK_W-1:0] link_wd;

  res_t              res_q, res_d;
  logic              res_we;

  // decode
  logic [SUM_W-1:0]  page_sum;
  logic [LINK_W-1:0] total_bufs;
  logic              add_err, id_ok, is_walk;
  logic [LINK_W-1:0] push_link;

  assign page_sum   = SUM_W'(pages_q) + SUM_W'(count_q);
  assign add_err    = (32'(count_q) > 32'(MAX_PAGES_PER_ADD)) ||
                      (page_sum > SUM_W'(POOL_PAGE_LIMIT));
  assign total_bufs = LINK_W'(32'(pages_q) * BUFFERS_PER_PAGE);
  assign id_ok      = (LINK_W'(id_q) < total_bufs);
  assign is_walk    = (action_q == ACT_ADD) && !add_err && (count_q != '0);
  assign push_link  = head_valid_q ? LINK_W'(head_id_q) : LINK_W'(MAX_BUFFERS);

  assign sts_o.walk      = is_walk;
  assign sts_o.walk_last = (off_q == total_q - WALK_W'(1));

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      count_q  <= page_count_i;
      base_q   <= base_address_i;
      id_q     <= buffer_id_i;
    end
  end

  // next list state, memory writes and result
  always_comb begin
    head_id_d    = head_id_q;
    head_valid_d = head_valid_q;
    pages_d      = pages_q;
    used_d       = used_q;
    link_we      = 1'b0;
    addr_we      = 1'b0;
    link_wa      = nid_q;
    link_wd      = push_link;
    res_we       = 1'b0;
    res_d        = '0;

    if (cmd_i.exec && !is_walk) begin
      res_we = 1'b1;
      case (action_q)
        ACT_ADD: begin
          res_d.status = add_err ? ST_ERROR : ST_OK;
        end
        ACT_GET: begin
          if (!head_valid_q) begin
            res_d.status = ST_EMPTY;
          end else begin
            res_d.status        = ST_OK;
            res_d.given_id      = head_id_q;
            res_d.given_address = rd_addr_q;
            if (rd_link_q < LINK_W'(MAX_BUFFERS)) begin
              head_id_d = rd_link_q[ID_W-1:0];
            end else begin
              head_id_d    = '0;
              head_valid_d = 1'b0;
            end
            if (used_q < USED_W'(MAX_BUFFERS)) begin
              used_d = used_q + USED_W'(1);
            end
          end
        end
        ACT_PUT: begin
          if (!id_ok) begin
            res_d.status = ST_ERROR;
          end else begin
            res_d.status       = ST_OK;
            res_d.put_on_empty = !head_valid_q;
            link_we            = 1'b1;
            link_wa            = id_q;
            head_id_d          = id_q;
            head_valid_d       = 1'b1;
            if (used_q != '0) begin
              used_d = used_q - USED_W'(1);
            end
          end
        end
        default: res_d.status = ST_ERROR;
      endcase
    end

    // one buffer of an add walk
    if (cmd_i.step) begin
      link_we      = 1'b1;
      addr_we      = 1'b1;
      head_id_d    = nid_q;
      head_valid_d = 1'b1;
    end

    // add walk complete
    if (cmd_i.done) begin
      res_we       = 1'b1;
      res_d.status = ST_OK;
      pages_d      = page_sum[PAGE_W-1:0];
    end

    res_d.used_count = used_d;
  end

  // list state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_id_q    <= '0;
      head_valid_q <= 1'b0;
      pages_q      <= '0;
      used_q       <= '0;
    end else begin
      head_id_q    <= head_id_d;
      head_valid_q <= head_valid_d;
      pages_q      <= pages_d;
      used_q       <= used_d;
    end
  end

  // walk counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_walk) begin
      nid_q   <= ID_W'(32'(pages_q) * BUFFERS_PER_PAGE);
      off_q   <= '0;
      total_q <= WALK_W'(32'(count_q) * BUFFERS_PER_PAGE);
      addr_q  <= base_q;
    end else if (cmd_i.step) begin
      nid_q  <= nid_q + ID_W'(1);
      off_q  <= off_q + WALK_W'(1);
      addr_q <= addr_q + ADDR_W'(STEP_BYTES);
    end
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    rd_link_q <= link_mem[head_id_q];
  end

  // address memory
  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[nid_q] <= addr_q;
    end
    rd_addr_q <= addr_mem[head_id_q];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/packet_buffer_free_list_unit.sv -----
// packet buffer free list: top level joining controller and datapath
// get, put, error and zero-page add items are transferred, then executed from the head read
// an add of n > 0 pages starts, walks its buffers, then closes; one link write per buffer
// a new item is taken while a result waits; its result load holds until that result is taken
// reset empties the list and clears the page and use counters; memories are not cleared
// depends on pbfl_pkg, pbfl_if, pbfl_ctrl, pbfl_datapath
module packet_buffer_free_list_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  pbfl_in_if.sink           in_i,
  pbfl_out_if.source        out_o
);
  import pbfl_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic in_ready;
  logic out_valid;

  // control
  pbfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  pbfl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (in_i.action),
    .page_count_i   (in_i.page_count),
    .base_address_i (in_i.base_address),
    .buffer_id_i    (in_i.buffer_id),
    .res_o          (res)
  );

  // channel outputs
  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.status        = res.status;
  assign out_o.given_id      = res.given_id;
  assign out_o.given_address = res.given_address;
  assign out_o.put_on_empty  = res.put_on_empty;
  assign out_o.used_count    = res.used_count;

`ifndef NO_ASSERTIONS
  // an accepted item blocks intake on the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("intake open right after a transfer");

  // an add walk never overlaps intake
  a_walk_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_ready)
    else $error("add walk while intake open");

  // use count stays within the pool
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.used_count <= USED_W'(MAX_BUFFERS)))
    else $error("used count beyond pool size");

  // failed items carry no buffer and no empty flag
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != ST_OK) |->
      (out_o.given_id == '0) && (out_o.given_address == '0) && !out_o.put_on_empty)
    else $error("failed item returned buffer data");
`endif

endmodule
